// ----- sv/hsbp_pkg.sv -----
// Package for the Huffman symbol bit packer: transaction payload types,
// operation codes and fixed field widths. No dependencies.
`default_nettype none

package hsbp_pkg;

    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 32;
    localparam int PEND_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 3;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [PAD_W-1:0]  pad_bits;
        logic              last;
    } t_out_item;

    // Table access strobes from the top level to the code table.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tab_ctl;

endpackage

`default_nettype wire

// ----- sv/hsbp_code_table.sv -----
// Code table for the Huffman symbol bit packer: one synchronous memory with
// registered read and per-entry valid bits. Depends on hsbp_pkg.
`default_nettype none

module hsbp_code_table #(
    parameter int DEPTH = 256,
    parameter int VAL_W = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  hsbp_pkg::t_tab_ctl          i_ctl,
    input  wire  [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  wire  [hsbp_pkg::LEN_W-1:0]        i_wr_len,
    input  wire  [VAL_W-1:0]                  i_wr_val,
    input  wire  [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic [hsbp_pkg::LEN_W-1:0]        o_rd_len,
    output logic [VAL_W-1:0]                  o_rd_val
);

    localparam int ENT_W = hsbp_pkg::LEN_W + VAL_W;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [ENT_W-1:0] r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_len, i_wr_val};
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry never written reads as length zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_hit <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_len = r_rd_hit ? r_rd_data[ENT_W-1 -: hsbp_pkg::LEN_W] : '0;
    assign o_rd_val = r_rd_data[VAL_W-1:0];

endmodule

`default_nettype wire

// ----- sv/huffman_symbol_bit_packer.sv -----
// Top level of the Huffman symbol bit packer: input decode, code table
// lookup and the byte packer with its output register. Depends on hsbp_pkg
// and hsbp_code_table.
`default_nettype none

// Huffman encoder back end. A load transaction (op 0) writes a symbol's code
// and length into the code table; an encode transaction (op 1) looks the
// symbol up and appends its code to the pending bits, and every complete
// byte leaves on the output channel, earliest code bit in bit 7, with last
// set on the final byte of that transaction. A flush (op 2) pads the
// leftover bits with zeros into one byte and reports the pad count. An
// accepted item's table read is registered, and the packer takes it from
// the lookup stage once the last byte of the previous item leaves. The
// packer emits one byte per cycle while the output is ready; an encode
// emits up to four bytes for a 32-bit code (up to (MAX_CODE_LEN+7)/8 in
// general) and a flush at most one. Loads skip the packer. Loads and
// encodes may arrive back to back; a load is visible to an encode accepted
// in the next cycle. The table comes out of reset empty, with no clearing
// pass.
module huffman_symbol_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  hsbp_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output hsbp_pkg::t_out_item        o_out_data
);

    localparam int LEN_W  = hsbp_pkg::LEN_W;
    localparam int PEND_W = hsbp_pkg::PEND_W;
    localparam int VAL_W  = (MAX_CODE_LEN < hsbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                              : hsbp_pkg::CODE_W;
    localparam int ACC_W  = MAX_CODE_LEN + PEND_W;
    localparam int NB     = ACC_W / 8;
    localparam int LEFT_W = $clog2(NB + 1);
    localparam int TOT_W  = $clog2(ACC_W + 1);
    localparam int ADDR_W = $clog2(SYMBOL_COUNT);

    // ---------------- input decode ----------------
    logic                 in_acc;
    logic                 in_range;
    logic [LEN_W-1:0]     sat_len;
    logic [VAL_W-1:0]     wr_val;
    logic [ADDR_W-1:0]    sym_idx;
    hsbp_pkg::t_tab_ctl   tab_ctl;
    logic [LEN_W-1:0]     rd_len;
    logic [VAL_W-1:0]     rd_val;

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_range = {1'b0, i_in_data.symbol} < 9'(SYMBOL_COUNT);
    assign sym_idx  = i_in_data.symbol[ADDR_W-1:0];

    // Saturate over-long codes and drop value bits above the length.
    assign sat_len = (i_in_data.code_length > LEN_W'(MAX_CODE_LEN)) ?
                     LEN_W'(MAX_CODE_LEN) : i_in_data.code_length;
    assign wr_val  = i_in_data.code_value[VAL_W-1:0] & ~({VAL_W{1'b1}} << sat_len);

    assign tab_ctl.wr_en = in_acc && (i_in_data.op == hsbp_pkg::OP_LOAD) && in_range;
    assign tab_ctl.rd_en = in_acc && (i_in_data.op == hsbp_pkg::OP_ENCODE) && in_range;

    hsbp_code_table #(
        .DEPTH (SYMBOL_COUNT),
        .VAL_W (VAL_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tab_ctl),
        .i_wr_addr (sym_idx),
        .i_wr_len  (sat_len),
        .i_wr_val  (wr_val),
        .i_rd_addr (sym_idx),
        .o_rd_len  (rd_len),
        .o_rd_val  (rd_val)
    );

    // ---------------- lookup stage ----------------
    // Holds an encode or flush while the table read completes. The table
    // read register holds its data while this stage stalls.
    logic r_s1_vld;
    logic r_s1_flush;
    logic n_s1_vld;
    logic s1_take;

    // ---------------- packer ----------------
    logic [ACC_W-1:0]          r_sh;
    logic [LEFT_W-1:0]         r_left;
    logic [hsbp_pkg::PAD_W-1:0] r_pad;
    logic [PEND_W-1:0]         r_pend_bits;
    logic [2:0]                r_pend_cnt;

    logic [ACC_W-1:0]          n_sh;
    logic [LEFT_W-1:0]         n_left;
    logic [hsbp_pkg::PAD_W-1:0] n_pad;
    logic [PEND_W-1:0]         n_pend_bits;
    logic [2:0]                n_pend_cnt;

    logic                      out_acc;
    logic [ACC_W-1:0]          acc;
    logic [TOT_W-1:0]          total;
    logic [hsbp_pkg::PAD_W-1:0] flush_pad;
    logic [7:0]                flush_byte;
    logic [ACC_W-1:0]          sel_sh;

    assign out_acc  = o_out_valid && i_out_ready;
    // Take the next item once the last byte of the current one leaves.
    assign s1_take  = r_s1_vld && ((r_left == '0) ||
                                   ((r_left == LEFT_W'(1)) && i_out_ready));
    assign o_in_ready = !r_s1_vld || s1_take;

    // Append the code below the pending bits.
    assign acc   = (ACC_W'(r_pend_bits) << rd_len) | ACC_W'(rd_val);
    assign total = TOT_W'(r_pend_cnt) + TOT_W'(rd_len);

    assign flush_pad  = hsbp_pkg::PAD_W'(4'd8 - {1'b0, r_pend_cnt});
    assign flush_byte = 8'({1'b0, r_pend_bits} << flush_pad);

    always_comb begin
        n_s1_vld    = r_s1_vld;
        n_sh        = r_sh;
        n_left      = r_left;
        n_pad       = r_pad;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;

        if (s1_take) begin
            n_s1_vld = 1'b0;
        end
        if (in_acc) begin
            n_s1_vld = (i_in_data.op == hsbp_pkg::OP_FLUSH) ||
                       ((i_in_data.op == hsbp_pkg::OP_ENCODE) && in_range);
        end

        if (out_acc) begin
            n_left = r_left - LEFT_W'(1);
        end

        if (s1_take) begin
            if (r_s1_flush) begin
                if (r_pend_cnt != 3'd0) begin
                    n_sh        = ACC_W'(flush_byte);
                    n_left      = LEFT_W'(1);
                    n_pad       = flush_pad;
                    n_pend_bits = '0;
                    n_pend_cnt  = 3'd0;
                end
            end else if (rd_len != '0) begin
                // Drop the leftover bits so whole bytes sit at the bottom.
                n_sh        = acc >> total[2:0];
                n_left      = LEFT_W'(total >> 3);
                n_pad       = '0;
                n_pend_cnt  = total[2:0];
                n_pend_bits = PEND_W'(acc) & ~({PEND_W{1'b1}} << total[2:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_left      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= 3'd0;
        end else begin
            r_s1_vld    <= n_s1_vld;
            r_left      <= n_left;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_flush <= (i_in_data.op == hsbp_pkg::OP_FLUSH);
        end
        r_sh  <= n_sh;
        r_pad <= n_pad;
    end

    // Earliest remaining byte is the highest one still counted.
    assign sel_sh = r_sh >> {r_left - LEFT_W'(1), 3'b000};

    assign o_out_valid         = (r_left != '0);
    assign o_out_data.out_byte = sel_sh[7:0];
    assign o_out_data.pad_bits = r_pad;
    assign o_out_data.last     = (r_left == LEFT_W'(1));

endmodule

`default_nettype wire

// ----- sv/hsbp_checker.sv -----
// Port-level checker for the Huffman symbol bit packer and its bind to the
// top level. Depends on hsbp_pkg and huffman_symbol_bit_packer.
`default_nettype none

module hsbp_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_ready,
    input wire hsbp_pkg::t_in_item  i_in_data,
    input wire                      o_out_valid,
    input wire                      i_out_ready,
    input wire hsbp_pkg::t_out_item o_out_data
);

    // Output channel is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold a stalled output transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

    // Pad bits appear only on the final byte of a transaction.
    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.pad_bits != 3'd0) |-> o_out_data.last)
        else $error("pad bits on a non-final byte");

    // Bytes of one item leave without a gap.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a byte burst");

endmodule

bind huffman_symbol_bit_packer hsbp_checker u_hsbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
